@@ rtl/grid_nearest_zero_distance_map_core_defines.svh @@
// Assertion macros shared by the distance map RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef GRID_NEAREST_ZERO_DISTANCE_MAP_CORE_DEFINES_SVH
`define GRID_NEAREST_ZERO_DISTANCE_MAP_CORE_DEFINES_SVH

// Same-cycle implication.
`define GNDM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gndm assertion failed");

// Next-cycle implication.
`define GNDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gndm assertion failed");

`endif

@@ rtl/gndm_pkg.sv @@
package gndm_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int IDX_W    = 3;
  localparam int DIM_W    = 4;
  localparam int DIST_W   = 5;
  localparam int OUT_DIST_W = 4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Saturation value for a cell with no target seen yet.
  localparam dist_t FAR_AWAY = dist_t'(31);

  // Configuration register indexes.
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Requests from the pass engine to the distance RAM.
  typedef struct packed {
    logic  we;
    addr_t wa;
    dist_t wd;
    addr_t ra;
    addr_t rb;
  } dist_ram_req_t;

  function automatic dim_t clamp_dim(dim_t v, dim_t hi);
    dim_t res;
    res = v;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  // Candidate through a neighbor is its distance plus one, saturated.
  function automatic dist_t near_plus_one(dist_t cur, dist_t nb);
    logic [DIST_W:0] cand;
    dist_t           res;
    cand = {1'b0, nb} + (DIST_W + 1)'(1);
    if (cand > {1'b0, FAR_AWAY}) begin
      cand = {1'b0, FAR_AWAY};
    end
    res = (cand[DIST_W-1:0] < cur) ? cand[DIST_W-1:0] : cur;
    return res;
  endfunction

endpackage

@@ rtl/gndm_dist_ram.sv @@
module gndm_dist_ram (
  input  logic                   clk,
  input  gndm_pkg::dist_ram_req_t req,
  output gndm_pkg::dist_t        rd_a,
  output gndm_pkg::dist_t        rd_b
);

  gndm_pkg::dist_t mem_r [gndm_pkg::DEPTH];
  gndm_pkg::dist_t rd_a_r;
  gndm_pkg::dist_t rd_b_r;

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.wa] <= req.wd;
    end
    rd_a_r <= (req.we && (req.wa == req.ra)) ? req.wd : mem_r[req.ra];
    rd_b_r <= (req.we && (req.wa == req.rb)) ? req.wd : mem_r[req.rb];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

@@ rtl/gndm_pass_engine.sv @@
`include "grid_nearest_zero_distance_map_core_defines.svh"

module gndm_pass_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  gndm_pkg::dim_t          rows,
  input  gndm_pkg::dim_t          cols,
  input  logic                    cell_rd,
  input  gndm_pkg::dist_t         rd_a,
  input  gndm_pkg::dist_t         rd_b,
  output gndm_pkg::addr_t         cell_ra,
  output gndm_pkg::dist_ram_req_t req,
  output logic                    done
);

  typedef enum logic [1:0] {ST_IDLE, ST_FWD, ST_BWD} state_t;

  state_t           state_r;
  gndm_pkg::dim_t   rows_r;
  gndm_pkg::dim_t   cols_r;
  gndm_pkg::idx_t   row_r;
  gndm_pkg::idx_t   col_r;
  gndm_pkg::addr_t  k_r;

  logic             cmp_v_r;
  logic             cmp_bwd_r;
  logic             cmp_has_v_r;
  logic             cmp_has_h_r;
  logic             cmp_last_r;
  gndm_pkg::addr_t  cmp_k_r;
  gndm_pkg::dist_t  prev_r;
  logic             done_r;

  gndm_pkg::idx_t   rows_m1;
  gndm_pkg::idx_t   cols_m1;
  logic             issuing;
  logic             row_end;
  logic             grid_end;
  gndm_pkg::dist_t  d_cmp;

  assign rows_m1  = gndm_pkg::idx_t'(rows_r - gndm_pkg::dim_t'(1));
  assign cols_m1  = gndm_pkg::idx_t'(cols_r - gndm_pkg::dim_t'(1));
  assign issuing  = (state_r == ST_FWD) || (state_r == ST_BWD);
  assign row_end  = (state_r == ST_FWD) ? (col_r == cols_m1) : (col_r == '0);
  assign grid_end = (state_r == ST_FWD) ? (row_end && (row_r == rows_m1))
                                        : (row_end && (row_r == '0));

  // Forward pass reads the cell above, backward pass the cell below and itself.
  always_comb begin
    cell_ra = k_r;
    req.we  = cmp_v_r;
    req.wa  = cmp_k_r;
    req.wd  = d_cmp;
    req.ra  = k_r;
    if (state_r == ST_BWD) begin
      req.rb = k_r + gndm_pkg::addr_t'(cols_r);
    end else begin
      req.rb = k_r - gndm_pkg::addr_t'(cols_r);
    end
  end

  // The horizontal neighbor is the value computed in the previous cycle.
  always_comb begin
    d_cmp = cmp_bwd_r ? rd_a : (cell_rd ? gndm_pkg::FAR_AWAY : '0);
    if (cmp_has_v_r) begin
      d_cmp = gndm_pkg::near_plus_one(d_cmp, rd_b);
    end
    if (cmp_has_h_r) begin
      d_cmp = gndm_pkg::near_plus_one(d_cmp, prev_r);
    end
  end

  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmp_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      cmp_v_r <= issuing;
      done_r  <= cmp_v_r && cmp_last_r;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_FWD;
          end
        end
        ST_FWD: begin
          if (grid_end) begin
            state_r <= ST_BWD;
          end
        end
        ST_BWD: begin
          if (grid_end) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      rows_r <= rows;
      cols_r <= cols;
      row_r  <= '0;
      col_r  <= '0;
      k_r    <= '0;
    end else if (state_r == ST_FWD) begin
      // The last forward cell is also the first backward cell, so k holds.
      if (grid_end) begin
        row_r <= rows_m1;
        col_r <= cols_m1;
      end else begin
        k_r <= k_r + gndm_pkg::addr_t'(1);
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + gndm_pkg::idx_t'(1);
        end else begin
          col_r <= col_r + gndm_pkg::idx_t'(1);
        end
      end
    end else begin
      k_r <= k_r - gndm_pkg::addr_t'(1);
      if (row_end) begin
        col_r <= cols_m1;
        row_r <= row_r - gndm_pkg::idx_t'(1);
      end else begin
        col_r <= col_r - gndm_pkg::idx_t'(1);
      end
    end
    cmp_bwd_r <= (state_r == ST_BWD);
    cmp_k_r   <= k_r;
    cmp_last_r <= (state_r == ST_BWD) && grid_end;
    if (state_r == ST_BWD) begin
      cmp_has_v_r <= (row_r != rows_m1);
      cmp_has_h_r <= (col_r != cols_m1);
    end else begin
      cmp_has_v_r <= (row_r != '0);
      cmp_has_h_r <= (col_r != '0);
    end
    if (cmp_v_r) begin
      prev_r <= d_cmp;
    end
  end

  `GNDM_ASSERT_IMPL(a_start_idle, start, (state_r == ST_IDLE) && !cmp_v_r)
  `GNDM_ASSERT_IMPL(a_done_drained, done_r, !cmp_v_r && (state_r == ST_IDLE))
  `GNDM_ASSERT_IMPL(a_bwd_no_rise, cmp_v_r && cmp_bwd_r, d_cmp <= rd_a)

endmodule

@@ rtl/grid_nearest_zero_distance_map_core.sv @@
// City-block (4-connected) distance transform of a binary grid of up to 8 x 8
// cells. Cells arrive one per input transaction in row-major order, bit 0 of
// in_tdata, at one per cycle while the block is loading; the grid size comes
// from grid_rows (index 0) and grid_cols (index 1), where 0 counts as 1 and
// values above 8 count as 8. After the last cell, a forward and a backward
// raster pass run over the distance RAM, and the block then sends one result
// per cell in row-major order, reading each from the RAM before loading it
// into the output register; tlast marks the final cell. If the grid held no
// zero cell, every result has found (tuser) cleared and distance zero. Input
// is taken again as soon as the last result is in the output register.
`include "grid_nearest_zero_distance_map_core_defines.svh"

module grid_nearest_zero_distance_map_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] cell_value, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] out_row, [5:3] out_col, [9:6] distance, [15:10] zero
  output logic        out_tuser,  // [0] found
  output logic        out_tlast
);

  typedef enum logic [1:0] {ST_LOAD, ST_PASS, ST_EMIT_RD, ST_EMIT_LD} state_t;

  state_t                  state_r;
  gndm_pkg::dim_t          rows_r;
  gndm_pkg::dim_t          cols_r;
  gndm_pkg::cnt_t          load_cnt_r;
  logic                    any_zero_r;
  gndm_pkg::idx_t          em_row_r;
  gndm_pkg::idx_t          em_col_r;
  gndm_pkg::addr_t         em_k_r;

  logic                    out_valid_r;
  gndm_pkg::idx_t          out_row_r;
  gndm_pkg::idx_t          out_col_r;
  logic [gndm_pkg::OUT_DIST_W-1:0] out_dist_r;
  logic                    out_found_r;
  logic                    out_last_r;

  logic                    cell_mem_r [gndm_pkg::DEPTH];
  logic                    cell_rd_r;

  gndm_pkg::cnt_t          total;
  gndm_pkg::cnt_t          cnt_inc;
  gndm_pkg::idx_t          rows_m1;
  gndm_pkg::idx_t          cols_m1;
  logic                    in_acc;
  logic                    grid_done;
  logic                    emitting;
  logic                    out_load;
  logic                    emit_last;

  gndm_pkg::addr_t         cell_ra;
  gndm_pkg::dist_ram_req_t eng_req;
  gndm_pkg::dist_ram_req_t ram_req;
  gndm_pkg::dist_t         rd_a;
  gndm_pkg::dist_t         rd_b;
  logic                    eng_done;

  assign total     = gndm_pkg::cnt_t'(rows_r) * gndm_pkg::cnt_t'(cols_r);
  assign cnt_inc   = load_cnt_r + gndm_pkg::cnt_t'(1);
  assign rows_m1   = gndm_pkg::idx_t'(rows_r - gndm_pkg::dim_t'(1));
  assign cols_m1   = gndm_pkg::idx_t'(cols_r - gndm_pkg::dim_t'(1));
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign grid_done = cnt_inc >= total;
  assign emitting  = (state_r == ST_EMIT_RD) || (state_r == ST_EMIT_LD);
  assign out_load  = (state_r == ST_EMIT_LD) && (!out_valid_r || out_tready);
  assign emit_last = (em_row_r == rows_m1) && (em_col_r == cols_m1);

  always_comb begin
    ram_req = eng_req;
    if (emitting) begin
      ram_req.ra = em_k_r;
    end
  end

  gndm_pass_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == ST_LOAD) && in_acc && grid_done),
    .rows    (rows_r),
    .cols    (cols_r),
    .cell_rd (cell_rd_r),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .cell_ra (cell_ra),
    .req     (eng_req),
    .done    (eng_done)
  );

  gndm_dist_ram u_dist_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_mem_r[load_cnt_r[gndm_pkg::ADDR_W-1:0]] <= in_tdata[0];
    end
    cell_rd_r <= cell_mem_r[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rows_r      <= gndm_pkg::dim_t'(gndm_pkg::MAX_ROWS);
      cols_r      <= gndm_pkg::dim_t'(gndm_pkg::MAX_COLS);
      load_cnt_r  <= '0;
      any_zero_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          gndm_pkg::REG_GRID_ROWS:
            rows_r <= gndm_pkg::clamp_dim(cfg_wdata, gndm_pkg::dim_t'(gndm_pkg::MAX_ROWS));
          gndm_pkg::REG_GRID_COLS:
            cols_r <= gndm_pkg::clamp_dim(cfg_wdata, gndm_pkg::dim_t'(gndm_pkg::MAX_COLS));
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (!in_tdata[0]) begin
              any_zero_r <= 1'b1;
            end
            if (grid_done) begin
              load_cnt_r <= '0;
              state_r    <= ST_PASS;
            end else begin
              load_cnt_r <= cnt_inc;
            end
          end
        end
        ST_PASS: begin
          if (eng_done) begin
            state_r <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_load) begin
            if (emit_last) begin
              any_zero_r <= 1'b0;
              state_r    <= ST_LOAD;
            end else begin
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // Result payload and the emission walk need no reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_PASS) begin
      em_row_r <= '0;
      em_col_r <= '0;
      em_k_r   <= '0;
    end else if (out_load) begin
      em_k_r <= em_k_r + gndm_pkg::addr_t'(1);
      if (em_col_r == cols_m1) begin
        em_col_r <= '0;
        em_row_r <= em_row_r + gndm_pkg::idx_t'(1);
      end else begin
        em_col_r <= em_col_r + gndm_pkg::idx_t'(1);
      end
    end
    if (out_load) begin
      out_row_r   <= em_row_r;
      out_col_r   <= em_col_r;
      out_dist_r  <= any_zero_r ? rd_a[gndm_pkg::OUT_DIST_W-1:0] : '0;
      out_found_r <= any_zero_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_dist_r, out_col_r, out_row_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  `GNDM_ASSERT_IMPL(a_load_in_range, in_acc, load_cnt_r < gndm_pkg::cnt_t'(gndm_pkg::DEPTH))
  `GNDM_ASSERT_IMPL(a_done_in_pass, eng_done, state_r == ST_PASS)
  `GNDM_ASSERT_NEXT(a_last_returns, out_load && emit_last, (state_r == ST_LOAD) && !any_zero_r)

endmodule

@@ dv/grid_nearest_zero_distance_map_core_tb.sv @@
module grid_nearest_zero_distance_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 5 * gndm_pkg::DEPTH + 16;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 100;

  typedef struct packed {
    gndm_pkg::idx_t row;
    gndm_pkg::idx_t col;
    logic [3:0]     steps;
    logic           found;
    logic           last;
  } cell_result_t;

  typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_ONES, FILL_LONE_ZERO} fill_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] cell_value, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [2:0] out_row, [5:3] out_col, [9:6] distance, [15:10] zero
  logic        out_tuser;        // [0] found
  logic        out_tlast;

  // Shadow of the block: size registers, loaded cells and working distances.
  gndm_pkg::dim_t  rows_shadow = gndm_pkg::dim_t'(8);
  gndm_pkg::dim_t  cols_shadow = gndm_pkg::dim_t'(8);
  logic            grid_bits [gndm_pkg::DEPTH];
  gndm_pkg::dist_t dist_map [gndm_pkg::DEPTH];
  int unsigned     cells_loaded = 0;
  logic            zero_seen = 1'b0;

  cell_result_t distance_results [$];
  logic         cell_queue [$];
  int unsigned  cells_pushed = 0;
  int unsigned  cells_taken = 0;
  int unsigned  error_count = 0;

  bit          calm = 1'b1;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;

  grid_nearest_zero_distance_map_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(gndm_pkg::dim_t v, int unsigned hi);
    if (v == '0) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return 32'(v);
  endfunction

  function automatic gndm_pkg::dist_t relax(gndm_pkg::dist_t cur, gndm_pkg::dist_t nb);
    int unsigned cand;
    cand = nb + 1;
    if (cand > gndm_pkg::FAR_AWAY) begin
      cand = gndm_pkg::FAR_AWAY;
    end
    return (cand < cur) ? gndm_pkg::dist_t'(cand) : cur;
  endfunction

  // Loads one cell; once the grid is complete, runs both raster passes and
  // queues one expected result per cell in row-major order.
  function automatic void take_cell(logic v);
    int unsigned     nr, nc, total, k, n;
    int              r, c;
    gndm_pkg::dist_t d;
    cell_result_t    res;
    nr = eff_dim(rows_shadow, gndm_pkg::MAX_ROWS);
    nc = eff_dim(cols_shadow, gndm_pkg::MAX_COLS);
    total = nr * nc;
    if (cells_loaded < gndm_pkg::DEPTH) begin
      grid_bits[cells_loaded] = v;
    end
    if (!v) begin
      zero_seen = 1'b1;
    end
    cells_loaded++;
    if (cells_loaded < total) begin
      return;
    end
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        k = r * nc + c;
        d = grid_bits[k] ? gndm_pkg::FAR_AWAY : gndm_pkg::dist_t'(0);
        if (r > 0) d = relax(d, dist_map[k - nc]);
        if (c > 0) d = relax(d, dist_map[k - 1]);
        dist_map[k] = d;
      end
    end
    for (r = nr - 1; r >= 0; r--) begin
      for (c = nc - 1; c >= 0; c--) begin
        k = r * nc + c;
        d = dist_map[k];
        if (r + 1 < nr) d = relax(d, dist_map[k + nc]);
        if (c + 1 < nc) d = relax(d, dist_map[k + 1]);
        dist_map[k] = d;
      end
    end
    n = 0;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        k = r * nc + c;
        res.row   = gndm_pkg::idx_t'(r);
        res.col   = gndm_pkg::idx_t'(c);
        res.steps = zero_seen ? dist_map[k][3:0] : 4'd0;
        res.found = zero_seen;
        res.last  = (n + 1 == total);
        distance_results.push_back(res);
        n++;
      end
    end
    cells_loaded = 0;
    zero_seen = 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Sender: a new cell goes out only once the current one is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cell_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'b0, cell_queue.pop_front()};
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, including the long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      stall_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 49) == 0) begin
      stall_left <= $urandom_range(8, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cell_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        take_cell(in_tdata[0]);
        cells_taken++;
      end
      if (out_tvalid && out_tready) begin
        got.row   = out_tdata[2:0];
        got.col   = out_tdata[5:3];
        got.steps = out_tdata[9:6];
        got.found = out_tuser;
        got.last  = out_tlast;
        if (distance_results.size() == 0) begin
          error_count++;
          if (error_count <= 20) begin
            $display("%0t: unexpected result row %0d col %0d dist %0d found %0b last %0b",
                     $realtime, got.row, got.col, got.steps, got.found, got.last);
          end
        end else begin
          want = distance_results.pop_front();
          if (got.row != want.row || got.col != want.col || got.steps != want.steps ||
              got.found != want.found || got.last != want.last) begin
            error_count++;
            if (error_count <= 20) begin
              $display("%0t: expected row %0d col %0d dist %0d found %0b last %0b, got row %0d col %0d dist %0d found %0b last %0b",
                       $realtime, want.row, want.col, want.steps, want.found, want.last,
                       got.row, got.col, got.steps, got.found, got.last);
            end
          end
        end
      end
    end
  end

  task automatic set_reg(logic idx, gndm_pkg::dim_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gndm_pkg::REG_GRID_ROWS) begin
      rows_shadow = val;
    end else begin
      cols_shadow = val;
    end
  endtask

  task automatic set_size(gndm_pkg::dim_t nr, gndm_pkg::dim_t nc);
    set_reg(gndm_pkg::REG_GRID_ROWS, nr);
    set_reg(gndm_pkg::REG_GRID_COLS, nc);
  endtask

  // Waits until every queued cell is taken and every result has arrived,
  // then gives the block time to finish any pass in progress.
  task automatic wait_idle();
    while (cells_taken != cells_pushed || distance_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pattern(logic [7:0] bits, int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      cell_queue.push_back(bits[i]);
      cells_pushed++;
    end
  endtask

  task automatic push_cells(int unsigned count, fill_t fill, int zero_at);
    int unsigned i, spot;
    logic        v;
    spot = (zero_at < 0) ? $urandom_range(0, count - 1) : zero_at;
    for (i = 0; i < count; i++) begin
      case (fill)
        FILL_RANDOM: v = $urandom_range(0, 1);
        FILL_SPARSE: v = ($urandom_range(0, 7) != 0);
        FILL_ONES:   v = 1'b1;
        default:     v = (i != spot);
      endcase
      cell_queue.push_back(v);
      cells_pushed++;
    end
  endtask

  function automatic gndm_pkg::dim_t pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return gndm_pkg::dim_t'(0);
    end
    if (roll == 1) begin
      return gndm_pkg::dim_t'($urandom_range(9, 15));
    end
    return gndm_pkg::dim_t'($urandom_range(1, 4));
  endfunction

  initial begin
    int unsigned    random_items, phase, grids, g, total, part;
    gndm_pkg::dim_t nr, nc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Partial load at the reset size, then a smaller size that the loaded
    // cells already exceed: the next cell completes a 1 x 2 grid.
    push_pattern(8'h05, 3);
    wait_idle();
    set_size(gndm_pkg::dim_t'(1), gndm_pkg::dim_t'(2));
    push_pattern(8'h01, 1);
    wait_idle();

    // Single-cell grids, with and without a zero, and zero counts taken as one.
    set_size(gndm_pkg::dim_t'(1), gndm_pkg::dim_t'(1));
    push_pattern(8'h00, 1);
    push_pattern(8'h01, 1);
    wait_idle();
    set_size(gndm_pkg::dim_t'(0), gndm_pkg::dim_t'(0));
    push_pattern(8'h01, 1);
    wait_idle();

    // Oversized counts clamp to eight.
    set_size(gndm_pkg::dim_t'(15), gndm_pkg::dim_t'(1));
    push_pattern(8'h7F, 8);
    wait_idle();
    set_size(gndm_pkg::dim_t'(1), gndm_pkg::dim_t'(9));
    push_pattern(8'h7E, 8);
    wait_idle();

    // Loaded count lands exactly on the new cell count.
    set_size(gndm_pkg::dim_t'(2), gndm_pkg::dim_t'(3));
    push_pattern(8'h0B, 4);
    wait_idle();
    set_reg(gndm_pkg::REG_GRID_COLS, gndm_pkg::dim_t'(2));
    push_pattern(8'h01, 1);
    wait_idle();

    // Full-size grid with one zero in a corner reaches the largest distance.
    calm = 1'b0;
    set_size(gndm_pkg::dim_t'(8), gndm_pkg::dim_t'(12));
    case ($urandom_range(0, 3))
      0: push_cells(gndm_pkg::DEPTH, FILL_LONE_ZERO, 0);
      1: push_cells(gndm_pkg::DEPTH, FILL_LONE_ZERO, gndm_pkg::MAX_COLS - 1);
      2: push_cells(gndm_pkg::DEPTH, FILL_LONE_ZERO, gndm_pkg::DEPTH - gndm_pkg::MAX_COLS);
      default: push_cells(gndm_pkg::DEPTH, FILL_LONE_ZERO, gndm_pkg::DEPTH - 1);
    endcase
    random_items = gndm_pkg::DEPTH;

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      nr = pick_dim();
      nc = pick_dim();
      set_size(nr, nc);
      total = eff_dim(nr, gndm_pkg::MAX_ROWS) * eff_dim(nc, gndm_pkg::MAX_COLS);
      grids = $urandom_range(1, 3);
      if (phase == 0) begin
        // Hold the output long enough that the block must stall its input.
        calm = 1'b0;
        grids = 3;
        hold_asked++;
      end
      for (g = 0; g < grids; g++) begin
        push_cells(total, fill_t'($urandom_range(0, 3)), -1);
        random_items += total;
      end
      // Now and then leave a grid half loaded before the next size change.
      if (total > 1 && $urandom_range(0, 7) == 0) begin
        part = $urandom_range(1, total - 1);
        push_cells(part, FILL_RANDOM, -1);
        random_items += part;
      end
      phase++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("grid_nearest_zero_distance_map_core_tb: clean");
    end else begin
      $display("grid_nearest_zero_distance_map_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("grid_nearest_zero_distance_map_core_tb: errors");
    $finish;
  end

endmodule
